@@ src/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and codes for the heap sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  // Operation codes on the input channel
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Status reported by the sort sequencer to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } sort_status_t;

endpackage

`default_nettype wire

@@ src/hse_mem.sv @@
// ----------------------------------------------------------------------------
// hse_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ src/hse_sorter.sv @@
// ----------------------------------------------------------------------------
// hse_sorter
// Heapsort sequencer: builds a max-heap in the store, then extracts the root
// to the tail repeatedly. Each sift-down holds the sinking element in a
// register and writes it once, at its final position.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_sorter #(
  parameter int DW = 32,
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [CW-1:0]         count,
  output hse_pkg::sort_status_t      status,
  output logic      [AW-1:0]         rd_addr,
  input  wire logic [DW-1:0]         rd_data,
  output logic                       wr_en,
  output logic      [AW-1:0]         wr_addr,
  output logic      [DW-1:0]         wr_data
);

  localparam int LW = AW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NEXT    = 4'd1;
  localparam logic [3:0] S_HELD_RD = 4'd2;
  localparam logic [3:0] S_HELD    = 4'd3;
  localparam logic [3:0] S_CHILD   = 4'd4;
  localparam logic [3:0] S_RC      = 4'd5;
  localparam logic [3:0] S_CMP     = 4'd6;
  localparam logic [3:0] S_X_RD0   = 4'd7;
  localparam logic [3:0] S_X_RDK   = 4'd8;
  localparam logic [3:0] S_X_SW    = 4'd9;

  logic [3:0]    state;
  logic          building;
  logic [CW-1:0] kidx;
  logic [CW-1:0] hlen;
  logic [AW-1:0] pos;
  logic [DW-1:0] held;
  logic [DW-1:0] lval;
  logic          rc_ok;

  logic [CW-1:0] kidx_dec;
  logic [LW-1:0] lc;
  logic [LW-1:0] rc;
  logic [LW-1:0] hlen_ext;
  logic          l_gt;
  logic [DW-1:0] bestval;
  logic          take_r;

  assign kidx_dec = kidx - 1'b1;
  assign lc       = {1'b0, pos, 1'b1};
  assign rc       = lc + 1'b1;
  assign hlen_ext = {{(LW-CW){1'b0}}, hlen};
  assign l_gt     = $signed(lval) > $signed(held);
  assign bestval  = l_gt ? lval : held;
  assign take_r   = rc_ok && ($signed(rd_data) > $signed(bestval));

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_NEXT) && !building && (kidx == '0);

  // Read address per step
  always_comb begin
    unique case (state)
      S_CHILD: rd_addr = lc[AW-1:0];
      S_RC:    rd_addr = rc[AW-1:0];
      S_X_RD0: rd_addr = '0;
      S_X_RDK: rd_addr = kidx[AW-1:0];
      default: rd_addr = pos;
    endcase
  end

  // Write port: settle the held element, move a larger child up, or put the old root at the tail
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = held;
    unique case (state)
      S_CHILD: begin
        wr_en = (lc >= hlen_ext);
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_data;
        end else if (l_gt) begin
          wr_data = lval;
        end
      end
      S_X_SW: begin
        wr_en   = 1'b1;
        wr_addr = kidx[AW-1:0];
        wr_data = lval;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      building <= 1'b0;
      kidx     <= '0;
      hlen     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            hlen     <= count;
            kidx     <= count >> 1;
            building <= 1'b1;
            state    <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (building) begin
            if (kidx == '0) begin
              building <= 1'b0;
              kidx     <= hlen - 1'b1;
            end else begin
              pos   <= kidx_dec[AW-1:0];
              kidx  <= kidx_dec;
              state <= S_HELD_RD;
            end
          end else if (kidx == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_X_RD0;
          end
        end
        S_HELD_RD: state <= S_HELD;
        S_HELD: begin
          held  <= rd_data;
          state <= S_CHILD;
        end
        S_CHILD: begin
          if (lc >= hlen_ext) begin
            state <= S_NEXT;
          end else begin
            state <= S_RC;
          end
        end
        S_RC: begin
          lval  <= rd_data;
          rc_ok <= (rc < hlen_ext);
          state <= S_CMP;
        end
        S_CMP: begin
          if (take_r) begin
            pos   <= rc[AW-1:0];
            state <= S_CHILD;
          end else if (l_gt) begin
            pos   <= lc[AW-1:0];
            state <= S_CHILD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_X_RD0: state <= S_X_RDK;
        S_X_RDK: begin
          lval  <= rd_data;
          state <= S_X_SW;
        end
        S_X_SW: begin
          // old root goes to the tail, old tail sinks from the root
          held  <= rd_data;
          hlen  <= kidx;
          kidx  <= kidx_dec;
          pos   <= '0;
          state <= S_CHILD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/heap_sort_engine_top.sv @@
// ----------------------------------------------------------------------------
// heap_sort_engine_top
// Batch heapsort engine: loads values, returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): operation 0 loads value into the store,
//   operation 1 fetches the next sorted value. Loads give no output.
//   Output channel (out_valid/out_ready): one transaction per fetch carrying
//   sorted_value, last (final element of the batch), empty_res (nothing
//   stored) and overflow (loads were dropped because the store was full).
//   A fetch of an already sorted batch is a store read followed by the
//   output register. The first fetch of a batch first runs the sort in the
//   store: a heap-build sift-down starts by reading the held element, an
//   extraction by swapping root and tail; then each level descended reads
//   both children and compares them with the held element until it settles.
//   The output is registered: loads are accepted while a result waits;
//   a fetch waits until the output register is free or being taken.
//   Reset empties the batch and clears the flags; store contents are left.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine_top #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         operation,
  input  wire logic signed [DATA_WIDTH-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      sorted_value,
  output logic                              last,
  output logic                              empty_res,
  output logic                              overflow
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] rp;
  logic          sorted;
  logic          ovf;

  hse_pkg::sort_status_t sort_status;

  logic                  in_acc;
  logic                  load_acc;
  logic                  fetch_acc;
  logic                  is_empty;
  logic                  not_full;
  logic                  sort_start;
  logic [CW-1:0]         rp_inc;

  logic [AW-1:0]         srt_rd_addr;
  logic                  srt_wr_en;
  logic [AW-1:0]         srt_wr_addr;
  logic [DATA_WIDTH-1:0] srt_wr_data;

  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;

  assign in_ready   = (state == ST_IDLE) &&
                      (operation == hse_pkg::OP_LOAD || !out_valid || out_ready);
  assign in_acc     = in_valid && in_ready;
  assign load_acc   = in_acc && (operation == hse_pkg::OP_LOAD);
  assign fetch_acc  = in_acc && (operation == hse_pkg::OP_FETCH);
  assign is_empty   = (count == '0) || (rp >= count);
  assign not_full   = (count != CW'(STORE_DEPTH));
  assign sort_start = fetch_acc && !is_empty && !sorted;
  assign rp_inc     = rp + 1'b1;

  // Store port arbitration: the sorter owns the store while it runs
  always_comb begin
    if (state == ST_SORT) begin
      mem_rd_addr = srt_rd_addr;
      mem_wr_en   = srt_wr_en;
      mem_wr_addr = srt_wr_addr;
      mem_wr_data = srt_wr_data;
    end else begin
      mem_rd_addr = rp[AW-1:0];
      mem_wr_en   = load_acc && (sorted || not_full);
      mem_wr_addr = sorted ? '0 : count[AW-1:0];
      mem_wr_data = value;
    end
  end

  hse_mem #(
    .DEPTH (STORE_DEPTH),
    .DW    (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  hse_sorter #(
    .DW (DATA_WIDTH),
    .AW (AW),
    .CW (CW)
  ) u_sorter (
    .clk     (clk),
    .rst     (rst),
    .start   (sort_start),
    .count   (count),
    .status  (sort_status),
    .rd_addr (srt_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (srt_wr_en),
    .wr_addr (srt_wr_addr),
    .wr_data (srt_wr_data)
  );

  // Batch control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rp        <= '0;
      sorted    <= 1'b0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (load_acc) begin
            if (sorted) begin
              // drop the unread rest, start a new batch
              count  <= CW'(1);
              rp     <= '0;
              sorted <= 1'b0;
              ovf    <= 1'b0;
            end else if (not_full) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end else if (fetch_acc) begin
            if (is_empty) begin
              out_valid    <= 1'b1;
              sorted_value <= '0;
              last         <= 1'b0;
              empty_res    <= 1'b1;
              overflow     <= ovf;
              count        <= '0;
              rp           <= '0;
              sorted       <= 1'b0;
              ovf          <= 1'b0;
            end else if (!sorted) begin
              state <= ST_SORT;
            end else begin
              state <= ST_RESP;
            end
          end
        end
        ST_SORT: begin
          if (sort_status.done) begin
            sorted <= 1'b1;
            state  <= ST_READ;
          end
        end
        ST_READ: state <= ST_RESP;
        ST_RESP: begin
          out_valid    <= 1'b1;
          sorted_value <= mem_rd_data;
          empty_res    <= 1'b0;
          overflow     <= ovf;
          if (rp_inc == count) begin
            last   <= 1'b1;
            count  <= '0;
            rp     <= '0;
            sorted <= 1'b0;
            ovf    <= 1'b0;
          end else begin
            last <= 1'b0;
            rp   <= rp_inc;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Assertions
  a_sorter_owned: assert property (@(posedge clk) disable iff (rst)
    sort_status.busy |-> (state == ST_SORT))
    else $error("sorter running outside of sort phase");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == ST_IDLE))
    else $error("input accepted while a fetch is in progress");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("element count beyond store depth");

  a_empty_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(empty_res && last))
    else $error("empty result marked as last");

  a_resp_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) |-> (!out_valid || out_ready))
    else $error("result would overwrite a pending output");

endmodule

`default_nettype wire
